// ===== hdl/ssm_pkg.sv =====
package ssm_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Fixed field widths
    localparam int LIMIT_W       = 40;
    localparam int LENGTH_W      = 6;
    localparam int NEEDLE_WORDS  = 4;
    localparam int NEEDLE_CFG_BYTES = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CASE_EXACT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT   = 3'd6;

    typedef logic [7:0] octet_t;

    // Mode and limit as seen by the datapath
    typedef struct packed {
        logic               exact_cmp;
        logic [LIMIT_W-1:0] byte_limit;
    } cfg_ctrl_t;

    // Fold an ASCII upper-case letter to lower case unless exact
    function automatic octet_t fold(input octet_t c, input logic exact);
        octet_t r;
        r = c;
        if (!exact && (c inside {[8'h41:8'h5A]})) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== hdl/ssm_cfg.sv =====
module ssm_cfg #(
    parameter int MAX_NEEDLE = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ssm_pkg::cfg_ctrl_t                 ctrl,
    output logic [MAX_NEEDLE*8-1:0]            needle_aligned,
    output logic [MAX_NEEDLE-1:0]              needle_mask,
    output logic [$clog2(MAX_NEEDLE+1)-1:0]    needle_len
);
    import ssm_pkg::*;

    localparam int LEN_W = $clog2(MAX_NEEDLE+1);
    localparam int CMP_W = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;

    logic [CFG_DATA_W-1:0]    word_reg  [NEEDLE_WORDS];
    logic [CFG_DATA_W-1:0]    word_next [NEEDLE_WORDS];
    logic [LENGTH_W-1:0]      length_reg, length_next;
    cfg_ctrl_t                ctrl_reg, ctrl_next;

    logic [MAX_NEEDLE*8-1:0]  aligned_reg, aligned_next;
    logic [MAX_NEEDLE-1:0]    mask_reg, mask_next;
    logic [LEN_W-1:0]         len_reg, len_next;

    logic [MAX_NEEDLE*8-1:0]  needle_vec;
    logic [MAX_NEEDLE*8-1:0]  needle_rev;
    logic [LEN_W-1:0]         shift_bytes;

    // Register writes
    always_comb
    begin
        for (int w = 0; w < NEEDLE_WORDS; w++) begin
            word_next[w] = word_reg[w];
        end
        length_next = length_reg;
        ctrl_next   = ctrl_reg;
        if (cfg_write) begin
            case (cfg_index)
                CFG_NEEDLE_0_7:   word_next[0] = cfg_data;
                CFG_NEEDLE_8_15:  word_next[1] = cfg_data;
                CFG_NEEDLE_16_23: word_next[2] = cfg_data;
                CFG_NEEDLE_24_31: word_next[3] = cfg_data;
                CFG_NEEDLE_LEN:   length_next = cfg_data[LENGTH_W-1:0];
                CFG_CASE_EXACT:   ctrl_next.exact_cmp = cfg_data[0];
                CFG_BYTE_LIMIT:   ctrl_next.byte_limit = cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Derive the right-aligned needle from the incoming values so that it is
    // ready on the cycle after the write.
    always_comb
    begin
        for (int i = 0; i < MAX_NEEDLE; i++) begin
            if (i < NEEDLE_CFG_BYTES) begin
                needle_vec[i*8 +: 8] = word_next[i >> 3][(i & 7)*8 +: 8];
            end else begin
                needle_vec[i*8 +: 8] = 8'h00;
            end
        end
        for (int i = 0; i < MAX_NEEDLE; i++) begin
            needle_rev[(MAX_NEEDLE-1-i)*8 +: 8] = needle_vec[i*8 +: 8];
        end
        // clamp an overlong needle
        if (CMP_W'(length_next) > CMP_W'(MAX_NEEDLE)) begin
            len_next = LEN_W'(MAX_NEEDLE);
        end else begin
            len_next = LEN_W'(length_next);
        end
        shift_bytes  = LEN_W'(MAX_NEEDLE) - len_next;
        // aligned byte j holds needle byte len-1-j
        aligned_next = needle_rev >> {shift_bytes, 3'b000};
        mask_next    = ~({MAX_NEEDLE{1'b1}} << len_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int w = 0; w < NEEDLE_WORDS; w++) begin
                word_reg[w] <= '0;
            end
            length_reg              <= '0;
            ctrl_reg.exact_cmp      <= 1'b1;
            ctrl_reg.byte_limit     <= '1;
            aligned_reg             <= '0;
            mask_reg                <= '0;
            len_reg                 <= '0;
        end else begin
            for (int w = 0; w < NEEDLE_WORDS; w++) begin
                word_reg[w] <= word_next[w];
            end
            length_reg  <= length_next;
            ctrl_reg    <= ctrl_next;
            aligned_reg <= aligned_next;
            mask_reg    <= mask_next;
            len_reg     <= len_next;
        end
    end

    assign ctrl           = ctrl_reg;
    assign needle_aligned = aligned_reg;
    assign needle_mask    = mask_reg;
    assign needle_len     = len_reg;

endmodule

// ===== hdl/ssm_window.sv =====
module ssm_window #(
    parameter int MAX_NEEDLE = 32
) (
    input  logic [MAX_NEEDLE*8-1:0]                      window,
    input  logic [MAX_NEEDLE*8-1:0]                      needle_aligned,
    input  logic [MAX_NEEDLE-1:0]                        needle_mask,
    input  logic [$clog2(MAX_NEEDLE+1)-1:0]              needle_len,
    input  logic [((MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1)-1:0] fill,
    input  logic                                         exact,
    output logic                                         hit
);
    import ssm_pkg::*;

    localparam int LEN_W  = $clog2(MAX_NEEDLE+1);
    localparam int FILL_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int CW     = ((LEN_W > FILL_W) ? LEN_W : FILL_W) + 1;

    logic [MAX_NEEDLE-1:0] lane_ok;
    logic                  enough;

    // One comparator per window position; unused positions pass
    always_comb
    begin
        for (int j = 0; j < MAX_NEEDLE; j++) begin
            lane_ok[j] = !needle_mask[j] ||
                         (fold(window[j*8 +: 8], exact) ==
                          fold(needle_aligned[j*8 +: 8], exact));
        end
    end

    assign enough = (CW'(fill) + CW'(1)) >= CW'(needle_len);
    assign hit    = (needle_len != '0) && enough && (&lane_ok);

endmodule

// ===== hdl/substring_match_stream.sv =====
// Channel  | handshake            | payload
// ---------+----------------------+---------------------------
// input    | in_valid / in_ready  | data_byte, end_of_file
// output   | out_valid / out_ready| found, file_done
// config   | cfg_write            | cfg_index, cfg_data
//
// One item per clock while the output is not stalled; each result is registered
// and appears in the cycle after its item is accepted, set by the single window compare ahead of the result register.
// Reset clears the per-file fill, count and flag and loads the configuration defaults
// (exact compare, byte limit all ones, empty needle).
// A stalled output holds its result; a new item is still taken in the cycle
// the waiting result is taken.
// A configuration write takes effect for items accepted from the next cycle.
module substring_match_stream #(
    parameter int MAX_NEEDLE = 32,
    parameter int COUNT_BITS = 40
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           end_of_file,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic                           file_done
);
    import ssm_pkg::*;

    localparam int LEN_W     = $clog2(MAX_NEEDLE+1);
    localparam int FILL_W    = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int HIST_D    = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1;
    localparam int LIM_CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    cfg_ctrl_t               ctrl;
    logic [MAX_NEEDLE*8-1:0] needle_aligned;
    logic [MAX_NEEDLE-1:0]   needle_mask;
    logic [LEN_W-1:0]        needle_len;

    // Per-file state: raw history bytes (newest first), fill, count, flag
    octet_t                  hist_reg [HIST_D];
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [COUNT_BITS-1:0]   seen_reg, seen_next;
    logic                    match_reg, match_next;

    // Result register
    logic                    out_valid_reg, out_valid_next;
    logic                    found_reg, found_next;
    logic                    done_reg, done_next;

    logic                    accept;
    logic                    examine;
    logic                    hit;
    logic [MAX_NEEDLE*8-1:0] window;

    ssm_cfg #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .ctrl           (ctrl),
        .needle_aligned (needle_aligned),
        .needle_mask    (needle_mask),
        .needle_len     (needle_len)
    );

    // Window: current byte at position zero, then the history
    always_comb
    begin
        window[7:0] = data_byte;
        for (int j = 1; j < MAX_NEEDLE; j++) begin
            window[j*8 +: 8] = hist_reg[j-1];
        end
    end

    ssm_window #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_window (
        .window         (window),
        .needle_aligned (needle_aligned),
        .needle_mask    (needle_mask),
        .needle_len     (needle_len),
        .fill           (fill_reg),
        .exact          (ctrl.exact_cmp),
        .hit            (hit)
    );

    // Take a new item whenever the result register is free or being emptied
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Bytes beyond the limit are neither compared nor counted
    assign examine = LIM_CMP_W'(seen_reg) < LIM_CMP_W'(ctrl.byte_limit);

    always_comb
    begin
        fill_next      = fill_reg;
        seen_next      = seen_reg;
        match_next     = match_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        done_next      = done_reg;

        if (out_ready) begin
            out_valid_next = 1'b0;
        end

        if (accept) begin
            out_valid_next = 1'b1;
            found_next     = match_reg || (examine && hit);
            done_next      = end_of_file;

            if (examine) begin
                match_next = match_reg || hit;
                if (fill_reg < FILL_W'(MAX_NEEDLE - 1)) begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                // saturate the count at all ones
                if (seen_reg != '1) begin
                    seen_next = seen_reg + COUNT_BITS'(1);
                end
            end

            // close the file: drop history, count and flag
            if (end_of_file) begin
                fill_next  = '0;
                seen_next  = '0;
                match_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg      <= '0;
            seen_reg      <= '0;
            match_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            seen_reg      <= seen_next;
            match_reg     <= match_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: history only matters up to the fill count
    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        done_reg  <= done_next;
        if (accept && examine && (MAX_NEEDLE > 1)) begin
            hist_reg[0] <= data_byte;
            for (int k = 1; k < HIST_D; k++) begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign file_done = done_reg;

endmodule
